@@ rtl/sbtc_pkg.sv @@
// Shared types, codes and helpers for the serial buffer transfer controller.
// Depends on nothing; sbtc_ctrl and the top level refer to it by scoped names.
package sbtc_pkg;

    localparam int unsigned BUFFER_BYTES_DEFAULT = 256;

    // Item commands
    typedef enum logic [2:0] {
        CMD_REG_RD = 3'd0,
        CMD_REG_WR = 3'd1,
        CMD_BUF_RD = 3'd2,
        CMD_BUF_WR = 3'd3,
        CMD_RX     = 3'd4
    } cmd_t;

    // Register byte offsets
    localparam logic [7:0] REG_CONTROL = 8'h00;
    localparam logic [7:0] REG_START   = 8'h08;
    localparam logic [7:0] REG_COUNT   = 8'h0c;

    // Control register bits
    localparam int unsigned CTL_START_BIT = 5;
    localparam int unsigned CTL_CLEAR_BIT = 7;
    localparam int unsigned CTL_KEEP_W    = 5;

    // Result fields decided at accept time, carried to the output stage
    typedef struct packed {
        logic [7:0] reg_rdata;
        logic       rdata_from_buf;
        logic       tx_valid;
        logic       irq;
        logic       busy;
    } res_t;

    // Reduce a byte address modulo m (16 <= m <= 256) by four
    // conditional subtractions of m*8, m*4, m*2, m.
    function automatic logic [7:0] addr_reduce(input logic [7:0] a, input int unsigned m);
        logic [11:0] v;
        v = {4'b0000, a};
        for (int k = 3; k >= 0; k--) begin
            if (v >= 12'(m << k))
            begin
                v = v - 12'(m << k);
            end
        end
        return v[7:0];
    endfunction

endpackage

@@ rtl/sbtc_if.sv @@
// Handshake channel interfaces for the serial buffer transfer controller.
// Depends on nothing; carries valid, ready and the item or result payload.
interface sbtc_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] cmd;
    logic [7:0] addr;
    logic [7:0] wdata;
    logic [7:0] rx_byte;

    modport source (output valid, cmd, addr, wdata, rx_byte, input ready);
    modport sink   (input valid, cmd, addr, wdata, rx_byte, output ready);
endinterface

interface sbtc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] rdata;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       irq;
    logic       busy_res;

    modport source (output valid, rdata, tx_valid, tx_byte, irq, busy_res, input ready);
    modport sink   (input valid, rdata, tx_valid, tx_byte, irq, busy_res, output ready);
endinterface

@@ rtl/sbtc_buffer_ram.sv @@
// Buffer RAM: one write port, one registered read port, per-entry valid bits.
// Depends on nothing from the package; an entry never written reads as zero.
module sbtc_buffer_ram #(
    parameter int unsigned BUFFER_BYTES = 256,
    parameter int unsigned SLOT_W       = $clog2(BUFFER_BYTES)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_en,
    input  logic [SLOT_W-1:0] rd_slot,
    input  logic              wr_en,
    input  logic [SLOT_W-1:0] wr_slot,
    input  logic [7:0]        wr_data,
    output logic [7:0]        rd_data
);

    logic [7:0]              mem [BUFFER_BYTES];
    logic [BUFFER_BYTES-1:0] valid_reg;
    logic [7:0]              rd_word_reg;
    logic                    rd_hit_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_slot] <= wr_data;
        end
        if (rd_en)
        begin
            rd_word_reg <= mem[rd_slot];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_hit_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_slot] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_hit_reg <= valid_reg[rd_slot];
            end
        end
    end

    assign rd_data = rd_hit_reg ? rd_word_reg : 8'h00;

endmodule

@@ rtl/sbtc_ctrl.sv @@
// Register file and exchange sequencer: decodes each accepted item, updates
// control state and issues buffer reads and writes. Depends on sbtc_pkg.
module sbtc_ctrl #(
    parameter int unsigned BUFFER_BYTES = 256,
    parameter int unsigned SLOT_W       = $clog2(BUFFER_BYTES)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [2:0]        cmd,
    input  logic [7:0]        addr,
    input  logic [7:0]        wdata,
    input  logic [7:0]        rx_byte,
    output logic              rd_en,
    output logic [SLOT_W-1:0] rd_slot,
    output logic              wr_en,
    output logic [SLOT_W-1:0] wr_slot,
    output logic [7:0]        wr_data,
    output sbtc_pkg::res_t    res
);

    logic [sbtc_pkg::CTL_KEEP_W-1:0] control_reg, control_next;
    logic [7:0]        start_reg, start_next;
    logic [7:0]        count_reg, count_next;
    logic [7:0]        idx_reg, idx_next;
    logic [SLOT_W-1:0] cur_slot_reg, cur_slot_next;
    logic              active_reg, active_next;
    logic              irq_reg, irq_next;

    logic [7:0]        start_red;
    logic [7:0]        addr_red;
    logic [SLOT_W-1:0] adv_slot;
    logic              rd_req;
    logic              wr_req;

    assign start_red = sbtc_pkg::addr_reduce(start_reg, BUFFER_BYTES);
    assign addr_red  = sbtc_pkg::addr_reduce(addr, BUFFER_BYTES);
    assign adv_slot  = (cur_slot_reg == SLOT_W'(BUFFER_BYTES - 1)) ? '0
                                                                  : cur_slot_reg + SLOT_W'(1);

    always_comb
    begin
        control_next  = control_reg;
        start_next    = start_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        cur_slot_next = cur_slot_reg;
        active_next   = active_reg;
        irq_next      = irq_reg;
        rd_req        = 1'b0;
        rd_slot       = '0;
        wr_req        = 1'b0;
        wr_slot       = '0;
        wr_data       = 8'h00;
        res           = '0;

        unique case (sbtc_pkg::cmd_t'(cmd))
            sbtc_pkg::CMD_REG_RD:
            begin
                unique case (addr)
                    sbtc_pkg::REG_CONTROL: res.reg_rdata = 8'(control_reg);
                    sbtc_pkg::REG_START:   res.reg_rdata = start_reg;
                    sbtc_pkg::REG_COUNT:   res.reg_rdata = count_reg;
                    default:               res.reg_rdata = 8'h00;
                endcase
            end
            sbtc_pkg::CMD_REG_WR:
            begin
                unique case (addr)
                    sbtc_pkg::REG_CONTROL:
                    begin
                        if (wdata[sbtc_pkg::CTL_CLEAR_BIT])
                        begin
                            irq_next = 1'b0;
                        end
                        // Start only from idle; fetch the first byte to send
                        if (wdata[sbtc_pkg::CTL_START_BIT] && !active_reg)
                        begin
                            active_next   = 1'b1;
                            idx_next      = 8'h00;
                            cur_slot_next = start_red[SLOT_W-1:0];
                            rd_req        = 1'b1;
                            rd_slot       = start_red[SLOT_W-1:0];
                            res.tx_valid  = 1'b1;
                        end
                        control_next = wdata[sbtc_pkg::CTL_KEEP_W-1:0];
                    end
                    sbtc_pkg::REG_START:
                    begin
                        if (!active_reg)
                        begin
                            start_next = wdata;
                        end
                    end
                    sbtc_pkg::REG_COUNT:
                    begin
                        if (!active_reg)
                        begin
                            count_next = wdata;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            sbtc_pkg::CMD_BUF_RD:
            begin
                rd_req             = 1'b1;
                rd_slot            = addr_red[SLOT_W-1:0];
                res.rdata_from_buf = 1'b1;
            end
            sbtc_pkg::CMD_BUF_WR:
            begin
                wr_req  = 1'b1;
                wr_slot = addr_red[SLOT_W-1:0];
                wr_data = wdata;
            end
            sbtc_pkg::CMD_RX:
            begin
                if (active_reg)
                begin
                    // Replace the sent byte with the received one
                    wr_req  = 1'b1;
                    wr_slot = cur_slot_reg;
                    wr_data = rx_byte;
                    if (idx_reg >= count_reg)
                    begin
                        active_next = 1'b0;
                        idx_next    = 8'h00;
                        irq_next    = 1'b1;
                    end
                    else
                    begin
                        idx_next      = idx_reg + 8'd1;
                        cur_slot_next = adv_slot;
                        rd_req        = 1'b1;
                        rd_slot       = adv_slot;
                        res.tx_valid  = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase

        res.irq  = irq_next;
        res.busy = active_next;
    end

    assign rd_en = accept && rd_req;
    assign wr_en = accept && wr_req;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            control_reg  <= '0;
            start_reg    <= 8'h00;
            count_reg    <= 8'h00;
            idx_reg      <= 8'h00;
            cur_slot_reg <= '0;
            active_reg   <= 1'b0;
            irq_reg      <= 1'b0;
        end
        else if (accept)
        begin
            control_reg  <= control_next;
            start_reg    <= start_next;
            count_reg    <= count_next;
            idx_reg      <= idx_next;
            cur_slot_reg <= cur_slot_next;
            active_reg   <= active_next;
            irq_reg      <= irq_next;
        end
    end

endmodule

@@ rtl/serial_buffer_transfer_controller.sv @@
// Top level of the serial buffer transfer controller.
// Depends on sbtc_pkg, sbtc_if, sbtc_ctrl and sbtc_buffer_ram.
//
// Usage:
//   req carries one transaction per item: a register read or write, a buffer
//   read or write, or a byte received from the serial partner. rsp returns
//   exactly one transaction per item, in order: read data, the next byte to
//   shift out (tx_valid/tx_byte), the interrupt level and the busy flag.
//   Results: a result appears on rsp in the cycle after its item is accepted.
//   Throughput: one item per cycle while rsp is not stalled. Every item is
//   decoded and its buffer read and write are issued at the accept edge, where
//   the buffer RAM and the single output stage capture the result to wait.
//   Back-pressure: while rsp is stalled with a result waiting, req.ready is
//   low; it is high whenever the output stage is empty or being drained.
//   Reset: all registers, the interrupt and the exchange state clear at once,
//   and the buffer reads as all zero until each entry is written; items are
//   taken from the first cycle after reset.
module serial_buffer_transfer_controller #(
    parameter int unsigned BUFFER_BYTES = sbtc_pkg::BUFFER_BYTES_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    sbtc_in_if.sink           req,
    sbtc_out_if.source        rsp
);

    localparam int unsigned SLOT_W = $clog2(BUFFER_BYTES);

    logic              accept;
    logic              rd_en;
    logic [SLOT_W-1:0] rd_slot;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_slot;
    logic [7:0]        wr_data;
    logic [7:0]        buf_rd_data;
    sbtc_pkg::res_t    res;

    // Output stage: hold the result until rsp takes it
    logic              out_valid_reg;
    sbtc_pkg::res_t    out_res_reg;

    // Advance whenever the output stage is empty or draining this cycle
    assign req.ready = !out_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    sbtc_ctrl #(
        .BUFFER_BYTES (BUFFER_BYTES),
        .SLOT_W       (SLOT_W)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .cmd     (req.cmd),
        .addr    (req.addr),
        .wdata   (req.wdata),
        .rx_byte (req.rx_byte),
        .rd_en   (rd_en),
        .rd_slot (rd_slot),
        .wr_en   (wr_en),
        .wr_slot (wr_slot),
        .wr_data (wr_data),
        .res     (res)
    );

    // Read and write of one item never hit the same entry, and writes of
    // earlier items land at earlier edges, so no forwarding is needed.
    sbtc_buffer_ram #(
        .BUFFER_BYTES (BUFFER_BYTES),
        .SLOT_W       (SLOT_W)
    ) u_buffer (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_slot (rd_slot),
        .wr_en   (wr_en),
        .wr_slot (wr_slot),
        .wr_data (wr_data),
        .rd_data (buf_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            out_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_res_reg <= res;
        end
    end

    // Buffer read data is only refreshed on accept, so it holds during a stall
    assign rsp.valid    = out_valid_reg;
    assign rsp.rdata    = out_res_reg.rdata_from_buf ? buf_rd_data : out_res_reg.reg_rdata;
    assign rsp.tx_valid = out_res_reg.tx_valid;
    assign rsp.tx_byte  = out_res_reg.tx_valid ? buf_rd_data : 8'h00;
    assign rsp.irq      = out_res_reg.irq;
    assign rsp.busy_res = out_res_reg.busy;

endmodule

@@ test/sbtc_result_checker.sv @@
// Result checker for the serial buffer transfer controller: mirrors the block's
// state from accepted request transactions and compares every response.
// Depends on sbtc_pkg and the sbtc_in_if / sbtc_out_if interfaces.
module sbtc_result_checker #(
    parameter int unsigned BUFFER_BYTES = sbtc_pkg::BUFFER_BYTES_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    sbtc_in_if          req,
    sbtc_out_if         rsp,
    output int unsigned fail_count,
    output int unsigned pending,
    output int unsigned exchange_count,
    output int unsigned swapped_count
);
    import sbtc_pkg::*;

    localparam int unsigned REPORT_LIMIT = 10;

    typedef struct packed {
        logic [7:0] rdata;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       irq;
        logic       busy;
    } outcome_t;

    // Mirror of the block's registers, buffer and exchange state
    logic [4:0] ctl_bits;
    logic [7:0] base_addr;
    logic [7:0] last_index;
    logic [7:0] buf_mirror [BUFFER_BYTES];
    logic [8:0] pos;
    logic       active;
    logic       irq_mirror;

    outcome_t   outcome_q [$];

    function automatic int unsigned slot_of(input int unsigned a);
        return a % BUFFER_BYTES;
    endfunction

    // Apply one request transaction to the mirror and return its outcome
    function automatic outcome_t advance_mirror(input logic [2:0] c, input logic [7:0] a,
                                                input logic [7:0] w, input logic [7:0] rx);
        outcome_t o;
        o = '0;
        case (c)
            CMD_REG_RD:
            begin
                if (a == REG_CONTROL)
                    o.rdata = {3'b000, ctl_bits};
                else if (a == REG_START)
                    o.rdata = base_addr;
                else if (a == REG_COUNT)
                    o.rdata = last_index;
            end
            CMD_REG_WR:
            begin
                if (a == REG_CONTROL)
                begin
                    if (w[CTL_CLEAR_BIT])
                        irq_mirror = 1'b0;
                    if (w[CTL_START_BIT] && !active)
                    begin
                        active     = 1'b1;
                        pos        = '0;
                        o.tx_valid = 1'b1;
                        o.tx_byte  = buf_mirror[slot_of(32'(base_addr))];
                    end
                    ctl_bits = w[CTL_KEEP_W-1:0];
                end
                else if (a == REG_START)
                begin
                    if (!active)
                        base_addr = w;
                end
                else if (a == REG_COUNT)
                begin
                    if (!active)
                        last_index = w;
                end
            end
            CMD_BUF_RD:
                o.rdata = buf_mirror[slot_of(32'(a))];
            CMD_BUF_WR:
                buf_mirror[slot_of(32'(a))] = w;
            CMD_RX:
            begin
                if (active)
                begin
                    buf_mirror[slot_of(32'(base_addr) + 32'(pos))] = rx;
                    swapped_count++;
                    if (pos >= {1'b0, last_index})
                    begin
                        active     = 1'b0;
                        pos        = '0;
                        irq_mirror = 1'b1;
                        exchange_count++;
                    end
                    else
                    begin
                        pos        = pos + 9'd1;
                        o.tx_valid = 1'b1;
                        o.tx_byte  = buf_mirror[slot_of(32'(base_addr) + 32'(pos))];
                    end
                end
            end
            default: ;
        endcase
        o.irq  = irq_mirror;
        o.busy = active;
        return o;
    endfunction

    task automatic log_mismatch(input string what, input outcome_t want, input outcome_t seen);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
        begin
            $display("MISMATCH %s: expected rdata=%02h tx_valid=%b tx_byte=%02h irq=%b busy=%b,",
                     what, want.rdata, want.tx_valid, want.tx_byte, want.irq, want.busy);
            $display("    got rdata=%02h tx_valid=%b tx_byte=%02h irq=%b busy=%b",
                     seen.rdata, seen.tx_valid, seen.tx_byte, seen.irq, seen.busy);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        outcome_t want;
        outcome_t seen;
        if (!rst_n)
        begin
            ctl_bits       = '0;
            base_addr      = '0;
            last_index     = '0;
            pos            = '0;
            active         = 1'b0;
            irq_mirror     = 1'b0;
            for (int i = 0; i < BUFFER_BYTES; i++)
                buf_mirror[i] = '0;
            outcome_q.delete();
            fail_count     = 0;
            pending        = 0;
            exchange_count = 0;
            swapped_count  = 0;
        end
        else
        begin
            // Retire the response first: it always belongs to an older item
            if (rsp.valid && rsp.ready)
            begin
                seen = {rsp.rdata, rsp.tx_valid, rsp.tx_byte, rsp.irq, rsp.busy_res};
                if (outcome_q.size() == 0)
                    log_mismatch("response with no item outstanding", '0, seen);
                else
                begin
                    want = outcome_q.pop_front();
                    if (seen.rdata !== want.rdata || seen.tx_valid !== want.tx_valid ||
                        seen.tx_byte !== want.tx_byte || seen.irq !== want.irq ||
                        seen.busy !== want.busy)
                        log_mismatch("response fields", want, seen);
                end
            end
            if (req.valid && req.ready)
                outcome_q.push_back(advance_mirror(req.cmd, req.addr, req.wdata, req.rx_byte));
            pending = outcome_q.size();
        end
    end

endmodule

@@ test/tb_serial_buffer_transfer_controller.sv @@
// Testbench top for the serial buffer transfer controller: drives request
// transactions, throttles the response side and reports the verdict.
// Depends on sbtc_pkg, the sbtc interfaces and sbtc_result_checker.
module tb_serial_buffer_transfer_controller;
    import sbtc_pkg::*;

    localparam int unsigned DEPTH        = 256;
    localparam int unsigned RANDOM_ITEMS = 600;
    // Worst case is roughly 700 items, each waiting out a long sender gap and
    // a long receiver stall; take that several times over.
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned DRAIN_CYCLES = 4;

    // Command codes the block leaves unused; they must still be exercised
    localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
    localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;

    logic clk;
    logic rst_n;

    sbtc_in_if  req ();
    sbtc_out_if rsp ();

    int unsigned fail_count;
    int unsigned pending;
    int unsigned exchange_count;
    int unsigned swapped_count;
    int unsigned cycle_count = 0;
    int unsigned sent = 0;

    // Idling knobs, flipped per phase so that some stretches run flat out
    bit gaps_on   = 1'b0;
    bit stalls_on = 1'b0;

    serial_buffer_transfer_controller #(
        .BUFFER_BYTES (DEPTH)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    sbtc_result_checker #(
        .BUFFER_BYTES (DEPTH)
    ) u_result_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .req            (req),
        .rsp            (rsp),
        .fail_count     (fail_count),
        .pending        (pending),
        .exchange_count (exchange_count),
        .swapped_count  (swapped_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Mostly no gap, often a short one, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return 0;
        else if (roll < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    function automatic logic [7:0] rnd8();
        return 8'($urandom);
    endfunction

    // Mostly a mapped register offset, sometimes any byte
    function automatic logic [7:0] pick_reg_addr();
        case ($urandom_range(0, 3))
            0: return REG_CONTROL;
            1: return REG_START;
            2: return REG_COUNT;
            default: return rnd8();
        endcase
    endfunction

    // Throttle the response side: when stalls are on, hold ready low for a random
    // stall, then give it back before the next stall can start.
    initial
    begin : rsp_throttle
        int unsigned hold;
        hold = 0;
        rsp.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
            begin
                rsp.ready = 1'b0;
                hold--;
            end
            else
            begin
                rsp.ready = 1'b1;
                if (stalls_on)
                    hold = pick_gap();
            end
        end
    end

    // Present one request transaction at a falling edge and hold it until the
    // block takes it. Valid stays high into the next call when there is no gap.
    task automatic put_item(input logic [2:0] c, input logic [7:0] a,
                            input logic [7:0] w, input logic [7:0] rx);
        int unsigned gap;
        gap = gaps_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            req.valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        req.valid   = 1'b1;
        req.cmd     = c;
        req.addr    = a;
        req.wdata   = w;
        req.rx_byte = rx;
        do
            @(posedge clk);
        while (!req.ready);
        sent++;
    endtask

    // Drop valid and hold off until every outstanding result has come back
    task automatic drain();
        @(negedge clk);
        req.valid = 1'b0;
        wait (pending == 0);
    endtask

    // One stray transaction slipped into a running exchange
    task automatic meddle();
        case ($urandom_range(0, 3))
            0: put_item(CMD_BUF_RD, rnd8(), rnd8(), rnd8());
            1: put_item(CMD_BUF_WR, rnd8(), rnd8(), rnd8());
            2: put_item(CMD_REG_RD, pick_reg_addr(), rnd8(), rnd8());
            default: put_item(CMD_REG_WR, pick_reg_addr(), rnd8(), rnd8());
        endcase
    endtask

    // Arbitrary transactions of every command, spare codes included
    task automatic noise_burst();
        logic [2:0] c;
        logic [7:0] a;
        repeat ($urandom_range(3, 12))
        begin
            c = 3'($urandom_range(0, 7));
            a = $urandom_range(0, 1) ? pick_reg_addr() : rnd8();
            put_item(c, a, rnd8(), rnd8());
        end
    endtask

    // Well-formed exchange: set the window, start, answer every sent byte.
    // One in ten is abandoned early so a later start lands on a busy block.
    task automatic run_exchange(input logic [7:0] base, input logic [7:0] span);
        int unsigned replies;
        logic [7:0]  ctl;
        repeat ($urandom_range(0, 3))
            put_item(CMD_BUF_WR, base + 8'($urandom_range(0, span)), rnd8(), rnd8());
        put_item(CMD_REG_WR, REG_START, base, rnd8());
        put_item(CMD_REG_WR, REG_COUNT, span, rnd8());
        ctl = rnd8();
        ctl[CTL_START_BIT] = 1'b1;
        put_item(CMD_REG_WR, REG_CONTROL, ctl, rnd8());
        replies = 32'(span) + 1;
        if ($urandom_range(0, 9) == 0)
            replies = $urandom_range(0, span);
        for (int unsigned k = 0; k < replies; k++)
        begin
            if ($urandom_range(0, 6) == 0)
                meddle();
            put_item(CMD_RX, rnd8(), rnd8(), rnd8());
        end
        // Read back status and maybe a byte of the window, then maybe clear the irq
        put_item(CMD_REG_RD, REG_CONTROL, rnd8(), rnd8());
        if ($urandom_range(0, 1) == 0)
            put_item(CMD_BUF_RD, base + 8'($urandom_range(0, span)), rnd8(), rnd8());
        if ($urandom_range(0, 2) == 0)
        begin
            ctl = rnd8();
            ctl[CTL_CLEAR_BIT] = 1'b1;
            ctl[CTL_START_BIT] = 1'b0;
            put_item(CMD_REG_WR, REG_CONTROL, ctl, rnd8());
        end
    endtask

    initial
    begin : stimulus
        int unsigned target;
        logic [7:0]  span;
        bit          big_done;
        bit          paused;

        // Known values on every input before and during reset
        rst_n       = 1'b0;
        req.valid   = 1'b0;
        req.cmd     = CMD_REG_RD;
        req.addr    = '0;
        req.wdata   = '0;
        req.rx_byte = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: reset values, unmapped offsets, buffer extremes, spare codes
        put_item(CMD_REG_RD, REG_CONTROL, 8'h00, 8'h00);
        put_item(CMD_REG_RD, REG_START, 8'hff, 8'hff);
        put_item(CMD_REG_RD, REG_COUNT, 8'h00, 8'h00);
        put_item(CMD_REG_RD, 8'hff, 8'h00, 8'h00);
        put_item(CMD_REG_WR, 8'h04, 8'hff, 8'hff);
        put_item(CMD_BUF_WR, 8'h00, 8'hff, 8'h00);
        put_item(CMD_BUF_WR, 8'hff, 8'h81, 8'h00);
        put_item(CMD_BUF_RD, 8'hff, 8'h00, 8'h00);
        put_item(CMD_BUF_RD, 8'h00, 8'h00, 8'h00);
        // Received byte while idle: drop it
        put_item(CMD_RX, 8'h00, 8'h00, 8'hff);
        for (int unsigned c = CMD_SPARE_FIRST; c <= CMD_SPARE_LAST; c++)
            put_item(3'(c), 8'hff, 8'hff, 8'hff);

        // Exchange wrapping from the top of the buffer to the bottom, started
        // together with an irq clear and every kept control bit set
        put_item(CMD_REG_WR, REG_START, 8'hff, 8'h00);
        put_item(CMD_REG_WR, REG_COUNT, 8'h01, 8'h00);
        put_item(CMD_REG_WR, REG_CONTROL, 8'hff, 8'h00);
        // While busy: a second start, window writes and a buffer read
        put_item(CMD_REG_WR, REG_CONTROL, 8'h20, 8'h00);
        put_item(CMD_REG_WR, REG_START, 8'h00, 8'h00);
        put_item(CMD_REG_WR, REG_COUNT, 8'hff, 8'h00);
        put_item(CMD_BUF_RD, 8'h00, 8'h00, 8'h00);
        put_item(CMD_RX, 8'h00, 8'h00, 8'h00);
        put_item(CMD_RX, 8'hff, 8'h00, 8'hff);
        put_item(CMD_REG_RD, REG_CONTROL, 8'h00, 8'h00);
        // Clear and start in one write, then clear alone while busy
        put_item(CMD_REG_WR, REG_CONTROL, 8'ha0, 8'h00);
        put_item(CMD_REG_WR, REG_CONTROL, 8'h80, 8'h00);
        put_item(CMD_RX, 8'h00, 8'h00, 8'h5a);
        put_item(CMD_RX, 8'h00, 8'h00, 8'ha5);

        // Random: mostly well-formed exchanges with random content, some noise
        target   = sent + RANDOM_ITEMS;
        big_done = 1'b0;
        paused   = 1'b0;
        while (sent < target)
        begin
            gaps_on   = ($urandom_range(0, 3) != 0);
            stalls_on = ($urandom_range(0, 3) != 0);
            if (!paused && sent > target - RANDOM_ITEMS / 2)
            begin
                drain();
                paused = 1'b1;
            end
            if ($urandom_range(0, 3) == 0)
                noise_burst();
            else
            begin
                // One full-buffer exchange; the rest stay short
                if (!big_done && sent > target - RANDOM_ITEMS + 150)
                begin
                    span     = 8'hff;
                    big_done = 1'b1;
                end
                else if ($urandom_range(0, 7) == 0)
                    span = 8'($urandom_range(8, 40));
                else
                    span = 8'($urandom_range(0, 7));
                run_exchange(rnd8(), span);
            end
        end

        @(negedge clk);
        req.valid = 1'b0;
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d request transactions over %0d cycles.", sent, cycle_count);
        $display("Exchanges finished: %0d, bytes swapped through the buffer: %0d.",
                 exchange_count, swapped_count);
        if (fail_count == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
